FILE: design/gst_pkg.sv
package gst_pkg;

  localparam int DEPTH_BITS  = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 32;
  localparam int RES_SLOTS   = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_DOT        = 8'h2E;

  typedef enum logic [3:0] {
    K_IDCHAR   = 4'd0,
    K_IDEND    = 4'd1,
    K_BLKCHAR  = 4'd2,
    K_BLKEND   = 4'd3,
    K_PUNCT    = 4'd4,
    K_END      = 4'd5,
    K_CMTERR   = 4'd6,
    K_BLKERR   = 4'd7,
    K_OVERFLOW = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic        first;
    logic [31:0] start_offset;
    logic [31:0] start_line;
  } res_t;

  // One slot pair per accepted item that causes a result; cnt is 1 or 2.
  typedef struct packed {
    logic [1:0]               cnt;
    res_t [RES_SLOTS-1:0]     res;
  } bundle_t;

  function automatic logic ident_start(input logic [7:0] b);
    return b == CH_UNDERSCORE || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic ident_cont(input logic [7:0] b);
    return ident_start(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

endpackage

FILE: design/gst_front.sv
module gst_front
  import gst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  input  logic       q_full,
  output logic       push,
  output bundle_t    push_data
);

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_LINE_CMT, M_BLOCK_CMT, M_IDENT, M_BLOCK_START, M_BLOCK
  } mode_t;

  mode_t                  mode, mode_next;
  logic [DEPTH_BITS-1:0]  brace_level, brace_level_next, brace_dec;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] token_offset, token_offset_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [LINE_BITS-1:0]   token_line, token_line_next;
  logic                   star_seen, star_seen_next;
  logic                   cr_seen, cr_seen_next;
  logic                   do_idle;
  logic [1:0]             n;
  res_t [RES_SLOTS-1:0]   r;
  logic                   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (n != 2'd0);
  assign push_data.cnt = n;
  assign push_data.res = r;

  always_comb begin
    mode_next         = mode;
    brace_level_next  = brace_level;
    byte_offset_next  = byte_offset;
    token_offset_next = token_offset;
    line_count_next   = line_count;
    token_line_next   = token_line;
    star_seen_next    = star_seen;
    cr_seen_next      = cr_seen;
    do_idle           = 1'b0;
    n                 = 2'd0;
    r                 = '0;
    brace_dec         = (brace_level != '0) ? brace_level - 1'b1 : brace_level;

    if (end_of_input) begin
      unique case (mode)
        M_IDENT: begin
          r[n[0]] = '{K_IDEND, 8'h00, 1'b0, 32'(token_offset), token_line};
          n = n + 2'd1;
        end
        M_SLASH: begin
          r[n[0]] = '{K_PUNCT, CH_SLASH, 1'b0, 32'(token_offset), token_line};
          n = n + 2'd1;
        end
        M_BLOCK_CMT: begin
          r[n[0]] = '{K_CMTERR, 8'h00, 1'b0, 32'(token_offset), token_line};
          n = n + 2'd1;
        end
        M_BLOCK_START, M_BLOCK: begin
          r[n[0]] = '{K_BLKERR, 8'h00, 1'b0, 32'(token_offset), token_line};
          n = n + 2'd1;
        end
        default: ;
      endcase
      r[n[0]] = '{K_END, 8'h00, 1'b0, 32'(byte_offset), line_count};
      n = n + 2'd1;
      mode_next         = M_IDLE;
      brace_level_next  = '0;
      byte_offset_next  = '0;
      token_offset_next = '0;
      line_count_next   = LINE_BITS'(1);
      token_line_next   = LINE_BITS'(1);
      star_seen_next    = 1'b0;
      cr_seen_next      = 1'b0;
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (ch == CH_STAR) begin
            mode_next      = M_BLOCK_CMT;
            star_seen_next = 1'b0;
          end else if (ch == CH_SLASH) begin
            mode_next = M_LINE_CMT;
          end else begin
            r[n[0]] = '{K_PUNCT, CH_SLASH, 1'b0, 32'(token_offset), token_line};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_LINE_CMT: begin
          if (ch == CH_CR || ch == CH_LF) mode_next = M_IDLE;
        end
        M_BLOCK_CMT: begin
          if (star_seen && ch == CH_SLASH) begin
            mode_next      = M_IDLE;
            star_seen_next = 1'b0;
          end else begin
            star_seen_next = (ch == CH_STAR);
          end
        end
        M_IDENT: begin
          if (ident_cont(ch)) begin
            r[n[0]] = '{K_IDCHAR, ch, 1'b0, 32'(token_offset), token_line};
            n = n + 2'd1;
          end else begin
            r[n[0]] = '{K_IDEND, 8'h00, 1'b0, 32'(token_offset), token_line};
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_BLOCK_START, M_BLOCK: begin
          if (ch == CH_LBRACE) begin
            if (brace_level == DEPTH_MAX) begin
              r[n[0]] = '{K_OVERFLOW, 8'h00, 1'b0, 32'(token_offset), token_line};
              n = n + 2'd1;
            end else begin
              brace_level_next = brace_level + 1'b1;
            end
            r[n[0]] = '{K_BLKCHAR, ch, mode == M_BLOCK_START, 32'(token_offset), token_line};
            n = n + 2'd1;
            mode_next = M_BLOCK;
          end else if (ch == CH_RBRACE) begin
            brace_level_next = brace_dec;
            if (brace_dec == '0) begin
              r[n[0]] = '{K_BLKEND, 8'h00, 1'b0, 32'(token_offset), token_line};
              n = n + 2'd1;
              mode_next = M_IDLE;
            end else begin
              r[n[0]] = '{K_BLKCHAR, ch, mode == M_BLOCK_START, 32'(token_offset), token_line};
              n = n + 2'd1;
              mode_next = M_BLOCK;
            end
          end else begin
            r[n[0]] = '{K_BLKCHAR, ch, mode == M_BLOCK_START, 32'(token_offset), token_line};
            n = n + 2'd1;
            mode_next = M_BLOCK;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // byte arriving between tokens
      if (do_idle) begin
        mode_next = M_IDLE;
        if (!(ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)) begin
          token_offset_next = byte_offset;
          token_line_next   = line_count;
          if (ch == CH_SLASH) begin
            mode_next = M_SLASH;
          end else if (ch == CH_LBRACE) begin
            mode_next        = M_BLOCK_START;
            brace_level_next = DEPTH_BITS'(1);
          end else if (ident_start(ch)) begin
            mode_next = M_IDENT;
            r[n[0]] = '{K_IDCHAR, ch, 1'b1, 32'(byte_offset), line_count};
            n = n + 2'd1;
          end else begin
            r[n[0]] = '{K_PUNCT, ch, 1'b0, 32'(byte_offset), line_count};
            n = n + 2'd1;
          end
        end
      end

      if ((ch == CH_CR || (ch == CH_LF && !cr_seen)) && line_count != LINE_MAX)
        line_count_next = line_count + 1'b1;
      cr_seen_next     = (ch == CH_CR);
      byte_offset_next = byte_offset + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      brace_level  <= '0;
      byte_offset  <= '0;
      token_offset <= '0;
      line_count   <= LINE_BITS'(1);
      token_line   <= LINE_BITS'(1);
      star_seen    <= 1'b0;
      cr_seen      <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      brace_level  <= brace_level_next;
      byte_offset  <= byte_offset_next;
      token_offset <= token_offset_next;
      line_count   <= line_count_next;
      token_line   <= token_line_next;
      star_seen    <= star_seen_next;
      cr_seen      <= cr_seen_next;
    end
  end

endmodule

FILE: design/gst_queue.sv
module gst_queue
  import gst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  output logic    not_empty,
  input  logic    pop,
  output bundle_t head
);

  bundle_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  assign full      = (count == QCNT_BITS'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/gst_back.sv
module gst_back
  import gst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  value,
  output logic        first,
  output logic [31:0] start_offset,
  output logic [31:0] start_line,
  output logic        last
);

  logic sub;
  res_t cur;

  assign cur          = head.res[sub];
  assign out_valid    = q_not_empty;
  assign kind         = cur.kind;
  assign value        = cur.value;
  assign first        = cur.first;
  assign start_offset = cur.start_offset;
  assign start_line   = cur.start_line;
  assign last         = sub || (head.cnt == 2'd1);
  assign pop          = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (out_valid && out_ready) begin
      sub <= !last;
    end
  end

endmodule

FILE: design/grammar_source_tokenizer_core.sv
// Grammar source tokenizer.
// Input channel (in_valid/in_ready): one source byte per beat on ch, or a beat
// with end_of_input set that closes the text and returns the tokenizer state to reset.
// Output channel (out_valid/out_ready): one token result per beat; last marks
// the final result caused by one input beat. An input beat causes zero, one or
// two results.
// Throughput: one input beat per cycle while the result queue has room; the
// output side drains one result per cycle while out_ready is high, so an input
// beat that causes two results costs two output beats. Items causing no result
// never enter the queue. Each result is registered in the queue before it leaves.
// The classifier updates its token state once per accepted beat and writes
// the results into a four-entry queue; the serializer behind it walks each
// entry. When the receiver stalls the queue fills and in_ready drops once all
// four entries are held. Reset empties the queue and puts the tokenizer
// between tokens at offset 0, line 1.
module grammar_source_tokenizer_core
  import gst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [7:0]  value,
  output logic        first,
  output logic [31:0] start_offset,
  output logic [31:0] start_line,
  output logic        last
);

  logic    q_full, q_not_empty, push, pop;
  bundle_t push_data, head;

  gst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  gst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head      (head)
  );

  gst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .value        (value),
    .first        (first),
    .start_offset (start_offset),
    .start_line   (start_line),
    .last         (last)
  );

endmodule

FILE: design/gst_checker.sv
module gst_checker
  import gst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  kind,
  input logic [7:0]  value,
  input logic        first,
  input logic [31:0] start_offset,
  input logic [31:0] start_line,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
      && $stable(start_offset) && $stable(start_line) && $stable(last))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_END |-> last)
    else $error("end result not last of its item");

  a_first_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && first |-> kind == K_IDCHAR || kind == K_BLKCHAR)
    else $error("first set on a non-character result");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(kind == K_IDCHAR || kind == K_BLKCHAR || kind == K_PUNCT) |-> value == 8'h00)
    else $error("nonzero value on a marker result");

endmodule

bind grammar_source_tokenizer_core gst_checker u_gst_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .value        (value),
  .first        (first),
  .start_offset (start_offset),
  .start_line   (start_line),
  .last         (last)
);

FILE: sim/grammar_source_tokenizer_core_test.sv
`timescale 1ns / 1ps

module grammar_source_tokenizer_core_test;
  import gst_pkg::*;

  localparam int CYCLE_LIMIT = 60000;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic        first;
    logic [31:0] start_offset;
    logic [31:0] start_line;
    logic        last;
  } tok_res_t;

  // one input beat; nt > 0 means the results are typed in by hand
  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
    logic [1:0] nt;
    tok_res_t   t0;
    tok_res_t   t1;
  } row_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SLASH, S_LINE_CMT, S_BLOCK_CMT, S_IDENT, S_BLOCK_START, S_BLOCK
  } scan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  kind;
  logic [7:0]  value;
  logic        first;
  logic [31:0] start_offset;
  logic [31:0] start_line;
  logic        last;

  grammar_source_tokenizer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .value        (value),
    .first        (first),
    .start_offset (start_offset),
    .start_line   (start_line),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  row_t     source_text[$];
  row_t     sent_bytes[$];
  tok_res_t exp_tokens[$];
  tok_res_t step_tokens[$];
  int       n_err = 0;
  int       cycles = 0;
  int       tx_gap_max = 12;
  int       rx_gap_max = 12;
  int       rx_hold = 0;

  // tokenizer state
  scan_t                  mode_r;
  logic [DEPTH_BITS-1:0]  depth_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [OFFSET_BITS-1:0] tok_off_r;
  logic [LINE_BITS-1:0]   line_r;
  logic [LINE_BITS-1:0]   tok_line_r;
  logic                   star_r;
  logic                   cr_r;

  function automatic tok_res_t tok(kind_t k, logic [7:0] v, logic f, logic [31:0] o,
                                   logic [31:0] l, logic lst);
    tok_res_t r;
    r.kind = k;
    r.value = v;
    r.first = f;
    r.start_offset = o;
    r.start_line = l;
    r.last = lst;
    return r;
  endfunction

  function automatic logic is_word(logic [7:0] b, logic allow_digit);
    logic [7:0] folded;
    folded = b | 8'h20;
    return b == CH_UNDERSCORE || (folded >= "a" && folded <= "z") ||
           (allow_digit && b >= "0" && b <= "9");
  endfunction

  task automatic scan_reset();
    mode_r = S_IDLE;
    depth_r = '0;
    off_r = '0;
    tok_off_r = '0;
    line_r = LINE_BITS'(1);
    tok_line_r = LINE_BITS'(1);
    star_r = 1'b0;
    cr_r = 1'b0;
  endtask

  task automatic emit_tok(kind_t k, logic [7:0] v, logic f, logic [OFFSET_BITS-1:0] o,
                          logic [LINE_BITS-1:0] l);
    step_tokens = {step_tokens, tok(k, v, f, o[31:0], l, 1'b0)};
  endtask

  task automatic open_token(logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return;
    tok_off_r = off_r;
    tok_line_r = line_r;
    if (b == CH_SLASH) begin
      mode_r = S_SLASH;
    end else if (b == CH_LBRACE) begin
      mode_r = S_BLOCK_START;
      depth_r = DEPTH_BITS'(1);
    end else if (is_word(b, 1'b0)) begin
      mode_r = S_IDENT;
      emit_tok(K_IDCHAR, b, 1'b1, tok_off_r, tok_line_r);
    end else begin
      emit_tok(K_PUNCT, b, 1'b0, tok_off_r, tok_line_r);
    end
  endtask

  task automatic block_byte(logic [7:0] b);
    logic f;
    f = (mode_r == S_BLOCK_START);
    mode_r = S_BLOCK;
    emit_tok(K_BLKCHAR, b, f, tok_off_r, tok_line_r);
  endtask

  task automatic tokenize_byte(logic [7:0] b, logic eoi);
    step_tokens.delete();
    if (eoi) begin
      case (mode_r)
        S_IDENT:                emit_tok(K_IDEND, 8'h00, 1'b0, tok_off_r, tok_line_r);
        S_SLASH:                emit_tok(K_PUNCT, CH_SLASH, 1'b0, tok_off_r, tok_line_r);
        S_BLOCK_CMT:            emit_tok(K_CMTERR, 8'h00, 1'b0, tok_off_r, tok_line_r);
        S_BLOCK_START, S_BLOCK: emit_tok(K_BLKERR, 8'h00, 1'b0, tok_off_r, tok_line_r);
        default: ;
      endcase
      emit_tok(K_END, 8'h00, 1'b0, off_r, line_r);
      scan_reset();
    end else begin
      case (mode_r)
        S_SLASH: begin
          if (b == CH_STAR) begin
            mode_r = S_BLOCK_CMT;
            star_r = 1'b0;
          end else if (b == CH_SLASH) begin
            mode_r = S_LINE_CMT;
          end else begin
            emit_tok(K_PUNCT, CH_SLASH, 1'b0, tok_off_r, tok_line_r);
            mode_r = S_IDLE;
            open_token(b);
          end
        end
        S_LINE_CMT: begin
          if (b == CH_CR || b == CH_LF) mode_r = S_IDLE;
        end
        S_BLOCK_CMT: begin
          // the star of the opener never counts toward the closer
          if (star_r && b == CH_SLASH) begin
            mode_r = S_IDLE;
            star_r = 1'b0;
          end else begin
            star_r = (b == CH_STAR);
          end
        end
        S_IDENT: begin
          if (is_word(b, 1'b1)) begin
            emit_tok(K_IDCHAR, b, 1'b0, tok_off_r, tok_line_r);
          end else begin
            emit_tok(K_IDEND, 8'h00, 1'b0, tok_off_r, tok_line_r);
            mode_r = S_IDLE;
            open_token(b);
          end
        end
        S_BLOCK_START, S_BLOCK: begin
          if (b == CH_LBRACE) begin
            if (depth_r == DEPTH_MAX) emit_tok(K_OVERFLOW, 8'h00, 1'b0, tok_off_r, tok_line_r);
            else depth_r = depth_r + 1'b1;
            block_byte(b);
          end else if (b == CH_RBRACE) begin
            if (depth_r != 0) depth_r = depth_r - 1'b1;
            if (depth_r == 0) begin
              emit_tok(K_BLKEND, 8'h00, 1'b0, tok_off_r, tok_line_r);
              mode_r = S_IDLE;
            end else begin
              block_byte(b);
            end
          end else begin
            block_byte(b);
          end
        end
        default: begin
          mode_r = S_IDLE;
          open_token(b);
        end
      endcase
      if ((b == CH_CR || (b == CH_LF && !cr_r)) && line_r != LINE_MAX) line_r = line_r + 1'b1;
      cr_r = (b == CH_CR);
      off_r = off_r + 1'b1;
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size()-1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    row_t     row;
    tok_res_t want;
    if (rst) begin
      scan_reset();
    end else begin
      if (in_valid && in_ready) begin
        row = sent_bytes.pop_front();
        tokenize_byte(ch, end_of_input);
        if (row.nt != 0) begin
          exp_tokens = {exp_tokens, row.t0};
          if (row.nt == 2) exp_tokens = {exp_tokens, row.t1};
        end else begin
          foreach (step_tokens[i]) exp_tokens = {exp_tokens, step_tokens[i]};
        end
      end
      if (out_valid && out_ready) begin
        if (exp_tokens.size() == 0) begin
          n_err++;
          $error("unexpected result: kind %0d value 0x%0h", kind, value);
        end else begin
          want = exp_tokens.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("value", 32'(want.value), 32'(value));
          check_field("first", 32'(want.first), 32'(first));
          check_field("start_offset", want.start_offset, start_offset);
          check_field("start_line", want.start_line, start_line);
          check_field("last", 32'(want.last), 32'(last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** grammar_source_tokenizer_core: FAILED **");
      $finish;
    end
  end

  // receiver
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic put(logic [7:0] c, logic e = 1'b0, int nt = 0, tok_res_t t0 = '0,
                     tok_res_t t1 = '0);
    row_t r;
    r.c = c;
    r.eoi = e;
    r.nt = 2'(nt);
    r.t0 = t0;
    r.t1 = t1;
    source_text = {source_text, r};
  endtask

  task automatic put_end();
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] ident_byte(logic tail);
    int k;
    k = $urandom_range(0, tail ? 62 : 52);
    if (k < 26) return 8'h61 + 8'(k);
    if (k < 52) return 8'h41 + 8'(k - 26);
    if (k == 52) return CH_UNDERSCORE;
    return 8'h30 + 8'(k - 53);
  endfunction

  // mostly well-formed tokens with random content, some noise and cut-off text
  task automatic gen_text(int target);
    int stop_at;
    int d;
    logic [7:0] b;
    stop_at = source_text.size() + target;
    while (source_text.size() < stop_at) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          put(ident_byte(1'b0));
          repeat ($urandom_range(0, 5)) put(ident_byte(1'b1));
        end
        3: begin
          case ($urandom_range(0, 4))
            0: put(CH_SPACE);
            1: put(CH_TAB);
            2: put(CH_CR);
            3: put(CH_LF);
            default: begin
              put(CH_CR);
              put(CH_LF);
            end
          endcase
        end
        4: put(($urandom_range(0, 1) != 0) ? CH_DOT : 8'($urandom_range(0, 255)));
        5: begin
          put(CH_SLASH);
          put(CH_SLASH);
          repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            put((b == CH_CR || b == CH_LF) ? CH_DOT : b);
          end
          put(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        end
        6: begin
          put(CH_SLASH);
          put(CH_STAR);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
              0: put(CH_STAR);
              1: put(CH_SLASH);
              default: put(8'($urandom_range(0, 255)));
            endcase
          end
          if ($urandom_range(0, 5) == 0) begin
            put_end();
          end else begin
            put(CH_STAR);
            put(CH_SLASH);
          end
        end
        7, 8: begin
          put(CH_LBRACE);
          d = 1;
          repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 5))
              0: begin
                if (d < 4) begin
                  put(CH_LBRACE);
                  d++;
                end
              end
              1: begin
                if (d > 1) begin
                  put(CH_RBRACE);
                  d--;
                end
              end
              default: begin
                b = 8'($urandom_range(0, 255));
                put((b == CH_LBRACE || b == CH_RBRACE) ? CH_CR : b);
              end
            endcase
          end
          if ($urandom_range(0, 5) == 0) put_end();
          else repeat (d) put(CH_RBRACE);
        end
        9: begin
          put(CH_SLASH);
          put(8'($urandom_range(0, 255)));
        end
        10: put(8'($urandom_range(0, 255)));
        default: put_end();
      endcase
    end
  endtask

  task automatic send_row(row_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_bytes = {sent_bytes, r};
    in_valid <= 1'b1;
    ch <= r.c;
    end_of_input <= r.eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_plan(logic vary);
    for (int i = 0; i < source_text.size(); i++) begin
      if (vary && i % 40 == 0) begin
        tx_gap_max = ((i / 40) % 3 == 2) ? 0 : 12;
        rx_gap_max = ((i / 40) % 3 == 1) ? 0 : 12;
      end
      send_row(source_text[i]);
    end
    source_text.delete();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    put(8'hA5, 1'b1, 1, tok(K_END, 8'h00, 1'b0, 32'd0, 32'd1, 1'b1));
    put("A", 1'b0, 1, tok(K_IDCHAR, "A", 1'b1, 32'd0, 32'd1, 1'b1));
    put(CH_UNDERSCORE);
    put(CH_DOT);
    put(8'hFF);
    put(8'h00);
    put(CH_CR);
    put(CH_LF);
    // slash-star-slash leaves the comment open
    put(CH_SLASH);
    put(CH_STAR);
    put(CH_SLASH);
    put(CH_STAR);
    put(CH_SLASH);
    put(CH_SLASH);
    put(CH_SLASH);
    put(CH_LF);
    // nested block with a lone CR
    put(CH_LBRACE);
    put(CH_CR);
    put(CH_LBRACE);
    put(CH_RBRACE);
    put(CH_RBRACE);
    put(CH_SLASH);
    put(CH_DOT);
    put(CH_SLASH);
    put("Z", 1'b1);
    put("b", 1'b0, 1, tok(K_IDCHAR, "b", 1'b1, 32'd0, 32'd1, 1'b1));
    put(8'h00, 1'b1, 2, tok(K_IDEND, 8'h00, 1'b0, 32'd0, 32'd1, 1'b0),
        tok(K_END, 8'h00, 1'b0, 32'd1, 32'd1, 1'b1));
    put(CH_SLASH);
    put(CH_STAR);
    put(8'hFF, 1'b1, 2, tok(K_CMTERR, 8'h00, 1'b0, 32'd0, 32'd1, 1'b0),
        tok(K_END, 8'h00, 1'b0, 32'd2, 32'd1, 1'b1));
    put(CH_LBRACE);
    put(8'h3C, 1'b1, 2, tok(K_BLKERR, 8'h00, 1'b0, 32'd0, 32'd1, 1'b0),
        tok(K_END, 8'h00, 1'b0, 32'd1, 32'd1, 1'b1));
    run_plan(1'b0);

    // long receiver stall against a back-to-back identifier
    tx_gap_max = 0;
    rx_hold = 120;
    put("p");
    repeat (30) put(ident_byte(1'b1));
    put(CH_SPACE);
    run_plan(1'b0);

    gen_text(150);
    run_plan(1'b1);

    // deep nesting, then cut the text off
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (6) put(CH_LBRACE);
    put(CH_RBRACE);
    put(CH_RBRACE);
    put_end();
    run_plan(1'b0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (exp_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("** grammar_source_tokenizer_core: PASSED **");
    end else begin
      $display("** grammar_source_tokenizer_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/gst_pkg.sv
design/gst_front.sv
design/gst_queue.sv
design/gst_back.sv
design/grammar_source_tokenizer_core.sv
design/gst_checker.sv
sim/grammar_source_tokenizer_core_test.sv
